// ===== design/bmo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bmo_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    // Wide enough for a frame dimension up to 8191.
    localparam int DIM_W          = 13;
    localparam int CFG_W          = 11;
    localparam int CFG_IDX_W      = 2;
    localparam int FIFO_DEPTH     = 2;

    localparam logic [7:0]       THRESHOLD_RST = 8'd128;
    localparam logic [CFG_W-1:0] FRAME_DIM_RST = 11'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_MODE         = 2'd1,
        CFG_FRAME_WIDTH  = 2'd2,
        CFG_FRAME_HEIGHT = 2'd3
    } t_cfg_idx;

    localparam logic [2:0] MODE_DILATE  = 3'd0;
    localparam logic [2:0] MODE_ERODE   = 3'd1;
    localparam logic [2:0] MODE_OPEN    = 3'd2;
    localparam logic [2:0] MODE_CLOSE   = 3'd3;
    localparam logic [2:0] MODE_HITMISS = 3'd4;

    typedef enum logic [1:0] {
        OP_DILATE = 2'd0,
        OP_ERODE  = 2'd1,
        OP_CORNER = 2'd2,
        OP_PASS   = 2'd3
    } t_op;

    typedef struct packed {
        logic       cmd;
        logic [7:0] pixel_value;
    } t_in;

    typedef struct packed {
        logic foreground;
        logic end_of_frame;
    } t_res;

    typedef struct packed {
        logic             pix;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [2:0]       mode;
    } t_entry;

    typedef struct packed {
        logic value;
        logic valid;
        logic last;
    } t_stage_out;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] ext;
        ext = DIM_W'(v);
        if (v == '0) begin
            return DIM_W'(1);
        end
        if (ext > maxv) begin
            return maxv;
        end
        return ext;
    endfunction

    function automatic t_op first_op(input logic [2:0] mode);
        case (mode)
            MODE_ERODE:   return OP_ERODE;
            MODE_OPEN:    return OP_ERODE;
            MODE_CLOSE:   return OP_DILATE;
            MODE_HITMISS: return OP_CORNER;
            default:      return OP_DILATE;
        endcase
    endfunction

    function automatic t_op second_op(input logic [2:0] mode);
        case (mode)
            MODE_OPEN:  return OP_DILATE;
            MODE_CLOSE: return OP_ERODE;
            default:    return OP_PASS;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== design/bmo_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bmo_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== design/bmo_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bmo_fifo #(
    parameter int DATA_W = 2,
    parameter int DEPTH  = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic      [DATA_W-1:0] o_data,
    output logic                   o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr, r_rd, n_wr, n_rd;
    logic [NW-1:0]     r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule
`default_nettype wire

// ===== design/bmo_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bmo_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [bmo_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [bmo_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                           i_push,
    input  wire bmo_pkg::t_in                   i_item,
    input  wire logic                           i_mid_full,
    output logic                                o_mid_push,
    output bmo_pkg::t_entry                     o_entry
);
    import bmo_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int DCW = $clog2(4 * MAX_WIDTH + 4);

    logic [7:0]       r_thr;
    logic [2:0]       r_mode;
    logic [CFG_W-1:0] r_fw, r_fh;

    logic             r_fresh, n_fresh;
    logic             r_drain, n_drain;
    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic [DCW-1:0]   r_dcnt, n_dcnt;
    logic [DIM_W-1:0] r_lw, r_lh, e_w, e_h;
    logic [2:0]       r_lmode, e_mode;
    logic             accept, ignore, last_col, last_row, drain_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THRESHOLD_RST;
            r_mode <= MODE_DILATE;
            r_fw   <= FRAME_DIM_RST;
            r_fh   <= FRAME_DIM_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD:    r_thr  <= i_cfg_data[7:0];
                CFG_MODE:         r_mode <= i_cfg_data[2:0];
                CFG_FRAME_WIDTH:  r_fw   <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_fh   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        e_w    = r_fresh ? clamp_dim(r_fw, DIM_W'(MAX_WIDTH)) : r_lw;
        e_h    = r_fresh ? clamp_dim(r_fh, DIM_W'(MAX_HEIGHT)) : r_lh;
        e_mode = r_fresh ? r_mode : r_lmode;

        accept     = i_push & ~i_mid_full;
        // A flush that arrives before the frame's last pixel is dropped.
        ignore     = ~r_drain & i_item.cmd;
        o_mid_push = accept & ~ignore;

        o_entry.pix  = ~r_drain & (i_item.pixel_value >= r_thr);
        o_entry.w    = e_w;
        o_entry.h    = e_h;
        o_entry.mode = e_mode;

        last_col   = (r_col == CW'(e_w - DIM_W'(1)));
        last_row   = (r_row == RW'(e_h - DIM_W'(1)));
        drain_last = (r_dcnt == ((DCW'(e_w) << 2) + DCW'(3)));

        n_fresh = r_fresh;
        n_drain = r_drain;
        n_col   = r_col;
        n_row   = r_row;
        n_dcnt  = r_dcnt;
        if (o_mid_push) begin
            n_fresh = 1'b0;
            if (!r_drain) begin
                n_col = last_col ? '0 : r_col + CW'(1);
                if (last_col) begin
                    n_row = r_row + RW'(1);
                end
                if (last_col && last_row) begin
                    n_drain = 1'b1;
                    n_dcnt  = '0;
                end
            end else if (drain_last) begin
                n_drain = 1'b0;
                n_fresh = 1'b1;
                n_col   = '0;
                n_row   = '0;
            end else begin
                n_dcnt = r_dcnt + DCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh <= 1'b1;
            r_drain <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
            r_dcnt  <= '0;
        end else begin
            r_fresh <= n_fresh;
            r_drain <= n_drain;
            r_col   <= n_col;
            r_row   <= n_row;
            r_dcnt  <= n_dcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_mid_push) begin
            r_lw    <= e_w;
            r_lh    <= e_h;
            r_lmode <= e_mode;
        end
    end
endmodule
`default_nettype wire

// ===== design/bmo_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bmo_stage #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_step,
    input  wire logic                      i_clear,
    input  wire logic                      i_bit,
    input  wire logic [bmo_pkg::DIM_W-1:0] i_w,
    input  wire logic [bmo_pkg::DIM_W-1:0] i_h,
    input  wire bmo_pkg::t_op              i_op,
    output bmo_pkg::t_stage_out            o_out
);
    import bmo_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int LW = $clog2(2 * MAX_WIDTH + 3);

    logic [CW-1:0]    r_col, n_col, r_ccol, n_ccol;
    logic [RW-1:0]    r_crow, n_crow;
    logic [LW-1:0]    r_warm, n_warm, lag;
    logic [4:0]       r_win [4];
    logic [4:0]       v [5];
    logic [3:0]       ram_q, rd_word, wr_word, r_byp_data;
    logic             r_byp;
    logic [4:0]       col_in, row_ok, col_ok;
    logic [DIM_W-1:0] w_m1, h_m1;
    logic [DIM_W:0]   crx, ccx, hx, wx;
    logic             valid, col_last, ccol_last, crow_last;
    logic             dil, ero, hit, res;

    bmo_ram #(
        .WIDTH (4),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (i_step),
        .i_waddr (r_col),
        .i_wdata (wr_word),
        .i_raddr (n_col),
        .o_rdata (ram_q)
    );

    always_comb begin
        w_m1      = i_w - DIM_W'(1);
        h_m1      = i_h - DIM_W'(1);
        lag       = (LW'(i_w) << 1) + LW'(2);
        valid     = (r_warm == lag);
        col_last  = (r_col == CW'(w_m1));
        ccol_last = (r_ccol == CW'(w_m1));
        crow_last = (r_crow == RW'(h_m1));

        rd_word = r_byp ? r_byp_data : ram_q;
        col_in  = {rd_word, i_bit};
        wr_word = {rd_word[2:0], i_bit};
        v[0]    = col_in;
        for (int j = 1; j < 5; j++) begin
            v[j] = r_win[j-1];
        end

        crx = (DIM_W+1)'(r_crow);
        ccx = (DIM_W+1)'(r_ccol);
        hx  = {1'b0, i_h};
        wx  = {1'b0, i_w};
        row_ok[0] = (crx + (DIM_W+1)'(2)) < hx;
        row_ok[1] = (crx + (DIM_W+1)'(1)) < hx;
        row_ok[2] = 1'b1;
        row_ok[3] = (crx >= (DIM_W+1)'(1));
        row_ok[4] = (crx >= (DIM_W+1)'(2));
        col_ok[0] = (ccx + (DIM_W+1)'(2)) < wx;
        col_ok[1] = (ccx + (DIM_W+1)'(1)) < wx;
        col_ok[2] = 1'b1;
        col_ok[3] = (ccx >= (DIM_W+1)'(1));
        col_ok[4] = (ccx >= (DIM_W+1)'(2));

        dil = 1'b0;
        ero = 1'b1;
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 5; j++) begin
                if (!((i == 0 || i == 4) && (j == 0 || j == 4))) begin
                    dil = dil | (row_ok[i] & col_ok[j] & v[j][i]);
                    ero = ero & (~(row_ok[i] & col_ok[j]) | v[j][i]);
                end
            end
        end

        // The hit set must be foreground and the miss set background where inside the frame.
        hit = (~(row_ok[2] & col_ok[3]) | v[3][2])
            & v[2][2]
            & (~(row_ok[1] & col_ok[2]) | v[2][1])
            & (~(row_ok[3] & col_ok[2]) | ~v[2][3])
            & (~(row_ok[3] & col_ok[1]) | ~v[1][3])
            & (~(row_ok[2] & col_ok[1]) | ~v[1][2]);

        case (i_op)
            OP_DILATE: res = dil;
            OP_ERODE:  res = ero;
            OP_CORNER: res = hit;
            OP_PASS:   res = v[2][2];
            default:   res = dil;
        endcase

        o_out.value = res;
        o_out.valid = valid;
        o_out.last  = valid & ccol_last & crow_last;

        n_col  = r_col;
        n_warm = r_warm;
        n_ccol = r_ccol;
        n_crow = r_crow;
        if (i_step) begin
            if (i_clear) begin
                n_col  = '0;
                n_warm = '0;
                n_ccol = '0;
                n_crow = '0;
            end else begin
                n_col = col_last ? '0 : r_col + CW'(1);
                if (!valid) begin
                    n_warm = r_warm + LW'(1);
                end else begin
                    n_ccol = ccol_last ? '0 : r_ccol + CW'(1);
                    if (ccol_last) begin
                        n_crow = r_crow + RW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_warm <= '0;
            r_ccol <= '0;
            r_crow <= '0;
            r_byp  <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_warm <= n_warm;
            r_ccol <= n_ccol;
            r_crow <= n_crow;
            r_byp  <= i_step && (r_col == n_col);
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= wr_word;
        if (i_step) begin
            r_win[0] <= col_in;
            for (int j = 1; j < 4; j++) begin
                r_win[j] <= r_win[j-1];
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/bmo_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bmo_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_mid_empty,
    input  wire bmo_pkg::t_entry i_entry,
    output logic                 o_mid_pop,
    input  wire logic            i_res_full,
    output logic                 o_res_push,
    output bmo_pkg::t_res        o_res
);
    import bmo_pkg::*;

    t_stage_out s1, s2;
    logic       step, eof;

    assign step       = ~i_mid_empty & ~i_res_full;
    assign o_mid_pop  = step;
    assign o_res_push = step & s2.valid;
    assign eof        = o_res_push & s2.last;

    assign o_res.foreground   = s2.value;
    assign o_res.end_of_frame = s2.last;

    bmo_stage #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_stage1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_clear (eof),
        .i_bit   (i_entry.pix),
        .i_w     (i_entry.w),
        .i_h     (i_entry.h),
        .i_op    (first_op(i_entry.mode)),
        .o_out   (s1)
    );

    bmo_stage #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_stage2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step & s1.valid),
        .i_clear (eof),
        .i_bit   (s1.value),
        .i_w     (i_entry.w),
        .i_h     (i_entry.h),
        .i_op    (second_op(i_entry.mode)),
        .o_out   (s2)
    );
endmodule
`default_nettype wire

// ===== design/binary_morphology_octagon_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Thresholds a raster stream of grey pixels and applies binary dilation, erosion, opening,
// closing over the 21-point octagon, or a hit-and-miss corner test. Each word popped from the
// middle queue steps the first window stage, and the second too once the first is valid, so
// the block sustains one word per cycle while the result queue has room; the rate is set by
// the one-step line stores and window registers of the two stages. The result for pixel k of
// a frame leaves with word k+4W+4 of that frame, counting words from zero (W the frame width),
// and a frame of W*H pixels must be followed by 4W+4 flush words to drain it. Frame size and
// mode are taken when the first pixel of a frame is accepted.
module binary_morphology_octagon_core #(
    parameter int MAX_WIDTH  = bmo_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmo_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bmo_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bmo_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          push,
    output logic                               full,
    input  wire bmo_pkg::t_in                  i_item,
    output logic                               empty,
    input  wire logic                          pop,
    output bmo_pkg::t_res                      o_result
);
    import bmo_pkg::*;

    t_entry front_entry, mid_entry;
    t_res   res_word;
    logic   mid_push, mid_full, mid_pop, mid_empty, res_push, res_full;

    assign full = mid_full;

    bmo_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_item     (i_item),
        .i_mid_full (mid_full),
        .o_mid_push (mid_push),
        .o_entry    (front_entry)
    );

    bmo_fifo #(
        .DATA_W ($bits(t_entry)),
        .DEPTH  (FIFO_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (front_entry),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_entry),
        .o_empty (mid_empty)
    );

    bmo_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (mid_empty),
        .i_entry     (mid_entry),
        .o_mid_pop   (mid_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_word)
    );

    bmo_fifo #(
        .DATA_W ($bits(t_res)),
        .DEPTH  (FIFO_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_word),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result word pushed into a full queue");

    a_mid_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_pop |-> !mid_empty)
        else $error("back end took a word from an empty queue");

    a_mid_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_push |-> !mid_full)
        else $error("front end pushed into a full queue");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");
endmodule
`default_nettype wire

// ===== tb/tb_binary_morphology_octagon_core.sv =====
`timescale 1ns / 1ps
module tb_binary_morphology_octagon_core;
    import bmo_pkg::*;

    localparam int MAX_DIM     = 1024;
    localparam int CELLS       = MAX_DIM * MAX_DIM;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 40;
    localparam int HOLD_CYCLES = 400;
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;
    localparam logic [2:0] MODE_SPARE_5 = 3'd5;
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    logic             push;
    logic             full;
    t_in              i_item;
    logic             empty;
    logic             pop;
    t_res             o_result;

    binary_morphology_octagon_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state.
    bit          thr_lines [0:CELLS-1];
    bit          stage_lines [0:CELLS-1];
    logic [7:0]  cur_threshold;
    logic [2:0]  cur_mode;
    logic [10:0] cur_width;
    logic [10:0] cur_height;
    int          frame_w, frame_h, frame_mode;
    int          pix_count, out_count, word_count;
    t_res        pending_pixels[$];
    logic [7:0]  pixel_script[$];

    int  errors;
    int  cycles;
    int  words_sent;
    int  words_checked;
    int  frames_sent;
    int  hold_req;
    bit  idle_en;

    function automatic int clamp_size(input logic [10:0] v);
        if (v == 0) begin
            return 1;
        end
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function automatic bit probe(input bit from_stage, input int r, input int c,
                                 input bit outside);
        if (r < 0 || c < 0 || r >= frame_h || c >= frame_w) begin
            return outside;
        end
        return from_stage ? stage_lines[r * frame_w + c] : thr_lines[r * frame_w + c];
    endfunction

    function automatic bit octagon(input bit from_stage, input int r, input int c,
                                   input bit erode);
        bit b;
        for (int dr = -2; dr <= 2; dr++) begin
            for (int dc = -2; dc <= 2; dc++) begin
                if (dr * dc == 4 || dr * dc == -4) begin
                    continue;
                end
                b = probe(from_stage, r + dr, c + dc, erode);
                if (erode && !b) begin
                    return 1'b0;
                end
                if (!erode && b) begin
                    return 1'b1;
                end
            end
        end
        return erode;
    endfunction

    function automatic bit corner_hit(input int r, input int c);
        if (!probe(0, r, c - 1, 1) || !probe(0, r, c, 1) || !probe(0, r + 1, c, 1)) begin
            return 1'b0;
        end
        if (probe(0, r - 1, c, 0) || probe(0, r - 1, c + 1, 0) || probe(0, r, c + 1, 0)) begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_word(input t_in w);
        int   n, lag, t, q, k;
        bit   res;
        t_res exp_word;
        if (word_count == 0) begin
            frame_w    = clamp_size(cur_width);
            frame_h    = clamp_size(cur_height);
            frame_mode = cur_mode;
        end
        n   = frame_w * frame_h;
        lag = 2 * frame_w + 2;
        if (pix_count < n) begin
            if (w.cmd == CMD_FLUSH) begin
                return;
            end
            thr_lines[pix_count] = (w.pixel_value >= cur_threshold);
            pix_count++;
        end
        t = word_count;
        word_count++;
        if (t >= lag && t - lag < n) begin
            q = t - lag;
            stage_lines[q] = octagon(0, q / frame_w, q % frame_w, frame_mode == MODE_OPEN);
        end
        if (t < 2 * lag) begin
            return;
        end
        k = t - 2 * lag;
        case (frame_mode)
            MODE_ERODE:   res = octagon(0, k / frame_w, k % frame_w, 1);
            MODE_OPEN:    res = octagon(1, k / frame_w, k % frame_w, 0);
            MODE_CLOSE:   res = octagon(1, k / frame_w, k % frame_w, 1);
            MODE_HITMISS: res = corner_hit(k / frame_w, k % frame_w);
            default:      res = octagon(0, k / frame_w, k % frame_w, 0);
        endcase
        out_count++;
        exp_word.foreground   = res;
        exp_word.end_of_frame = (out_count >= n);
        pending_pixels.insert(pending_pixels.size(), exp_word);
        if (out_count >= n) begin
            pix_count  = 0;
            out_count  = 0;
            word_count = 0;
        end
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on request.
    int stall_left;
    int hold_done;
    int hold_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_req != hold_done) begin
            pop <= 1'b0;
            hold_done = hold_req;
            hold_left = HOLD_CYCLES - 1;
        end else if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
        end else begin
            pop <= 1'b1;
            if (idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 9);
            end
        end
    end

    always @(posedge i_clk) begin
        t_res exp_word;
        if (i_rst_n && pop && !empty) begin
            words_checked++;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %b", $time, o_result);
                errors++;
            end else begin
                exp_word = pending_pixels.pop_front();
                if (o_result.foreground !== exp_word.foreground) begin
                    $display("%0t: foreground mismatch, expected %b, actual %b", $time,
                             exp_word.foreground, o_result.foreground);
                    errors++;
                end
                if (o_result.end_of_frame !== exp_word.end_of_frame) begin
                    $display("%0t: end_of_frame mismatch, expected %b, actual %b", $time,
                             exp_word.end_of_frame, o_result.end_of_frame);
                    errors++;
                end
            end
        end
    end

    task automatic send_word(input logic cmd, input logic [7:0] value);
        t_in w;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        w.cmd         = cmd;
        w.pixel_value = value;
        i_item <= w;
        push   <= 1'b1;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        predict_word(w);
        words_sent++;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic configure(input logic [7:0] thr, input logic [2:0] mode,
                             input logic [10:0] w, input logic [10:0] h);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_THRESHOLD;
        i_cfg_data <= CFG_W'(thr);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MODE;
        i_cfg_data <= CFG_W'(mode);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FRAME_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FRAME_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_threshold = thr;
        cur_mode      = mode;
        cur_width     = w;
        cur_height    = h;
    endtask

    function automatic logic [7:0] next_pixel();
        if (pixel_script.size() != 0) begin
            return pixel_script.pop_front();
        end
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            1:       return 8'(cur_threshold + $urandom_range(0, 3) - 2);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_frame(input logic [7:0] thr, input logic [2:0] mode,
                             input logic [10:0] w, input logic [10:0] h, input bit noisy);
        int n, drain;
        wait_idle();
        configure(thr, mode, w, h);
        n     = clamp_size(w) * clamp_size(h);
        drain = 2 * (2 * clamp_size(w) + 2);
        for (int p = 0; p < n; p++) begin
            if (noisy && $urandom_range(0, 9) == 0) begin
                send_word(CMD_FLUSH, 8'($urandom_range(0, 255)));
            end
            send_word(CMD_PIXEL, next_pixel());
        end
        for (int d = 0; d < drain; d++) begin
            if (noisy && $urandom_range(0, 5) == 0) begin
                send_word(CMD_PIXEL, 8'($urandom_range(0, 255)));
            end else begin
                send_word(CMD_FLUSH, 8'($urandom_range(0, 255)));
            end
        end
        frames_sent++;
    endtask

    task automatic test_pixel_levels();
        pixel_script = '{8'd0, 8'd255, 8'd99, 8'd100, 8'd101, 8'd255, 8'd0, 8'd100, 8'd99};
        run_frame(8'd100, MODE_DILATE, 11'd3, 11'd3, 0);
    endtask

    task automatic test_each_mode();
        run_frame(8'($urandom_range(0, 255)), MODE_DILATE, 11'd3, 11'd3, 0);
        run_frame(8'($urandom_range(0, 255)), MODE_ERODE, 11'd3, 11'd3, 0);
        run_frame(8'($urandom_range(0, 255)), MODE_OPEN, 11'd3, 11'd3, 0);
        run_frame(8'($urandom_range(0, 255)), MODE_CLOSE, 11'd3, 11'd3, 0);
        run_frame(8'($urandom_range(0, 255)), MODE_HITMISS, 11'd3, 11'd3, 0);
        run_frame(8'($urandom_range(0, 255)), MODE_SPARE_5, 11'd3, 11'd2, 0);
        run_frame(8'($urandom_range(0, 255)), MODE_SPARE_6, 11'd2, 11'd3, 0);
        run_frame(8'($urandom_range(0, 255)), MODE_SPARE_7, 11'd2, 11'd2, 0);
    endtask

    task automatic test_threshold_extremes();
        run_frame(8'd0, MODE_ERODE, 11'd4, 11'd3, 0);
        run_frame(8'd255, MODE_DILATE, 11'd4, 11'd3, 0);
    endtask

    task automatic test_frame_extremes();
        run_frame(8'd128, MODE_DILATE, 11'd1, 11'd1, 0);
        run_frame(8'd128, MODE_CLOSE, 11'd0, 11'd2, 0);
        run_frame(8'd128, MODE_HITMISS, 11'd3, 11'd1, 0);
        run_frame(8'd128, MODE_ERODE, 11'd2, 11'd0, 0);
    endtask

    task automatic test_stray_words();
        run_frame(8'($urandom_range(0, 255)), MODE_OPEN, 11'd5, 11'd4, 1);
        run_frame(8'($urandom_range(0, 255)), MODE_HITMISS, 11'd4, 11'd5, 1);
    endtask

    task automatic test_output_hold();
        wait_idle();
        hold_req++;
        run_frame(8'($urandom_range(0, 255)), MODE_CLOSE, 11'd6, 11'd6, 0);
    endtask

    task automatic test_random_frames(input int target);
        int start;
        start = words_sent;
        while (words_sent - start < target) begin
            run_frame(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                      11'($urandom_range(1, 8)), 11'($urandom_range(1, 8)),
                      $urandom_range(0, 3) == 0);
        end
    endtask

    initial begin
        words_sent    = 0;
        frames_sent   = 0;
        hold_req      = 0;
        idle_en       = 1'b1;
        pix_count     = 0;
        out_count     = 0;
        word_count    = 0;
        cur_threshold = THRESHOLD_RST;
        cur_mode      = MODE_DILATE;
        cur_width     = FRAME_DIM_RST;
        cur_height    = FRAME_DIM_RST;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_THRESHOLD;
        i_cfg_data <= '0;
        push       <= 1'b0;
        i_item     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pixel_levels();
        test_each_mode();
        test_threshold_extremes();
        test_frame_extremes();
        test_stray_words();
        test_output_hold();
        test_random_frames(300);
        idle_en = 1'b0;
        test_random_frames(120);

        wait_idle();
        $display("Covered %0d frames in all eight mode codes, %0d input words, %0d results.",
                 frames_sent, words_sent, words_checked);
        $display("Frame sizes ran from 1x1 to 8x8 with zero sizes, early flushes, "
                 , "extra pixels and a long output stall.");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
